// ----- hdl/http_body_chunked_decoder_unit_defines.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef HTTP_BODY_CHUNKED_DECODER_UNIT_DEFINES_SVH
`define HTTP_BODY_CHUNKED_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH

`define HBCD_ASSERT(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define HBCD_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define HBCD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define HBCD_ASSERT(name, clk, rstn, prop, msg)

`define HBCD_ASSERT_NOW(name, clk, rstn, ante, cons, msg)

`define HBCD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- hdl/hbcd_pkg.sv -----
package hbcd_pkg;

	localparam int CL_BITS = 32;

	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_LENGTH = 2'd1;
	localparam logic [1:0] MODE_CHUNK  = 2'd2;
	localparam logic [1:0] MODE_STREAM = 2'd3;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_LINE  = 2'd1;
	localparam logic [1:0] ERR_OVF   = 2'd2;
	localparam logic [1:0] ERR_EARLY = 2'd3;

	localparam logic [0:0] CFG_BODY_MODE = 1'b0;
	localparam logic [0:0] CFG_BODY_LEN  = 1'b1;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [1:0] SKIP_COUNT = 2'd2;

	typedef struct packed {
		logic [1:0]         body_mode;
		logic [CL_BITS-1:0] body_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       chunk_last;
		logic       body_done;
		logic [1:0] error_code;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			h.val = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			h.val = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ----- hdl/hbcd_in_if.sv -----
interface hbcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source(output valid, output data_byte, output stream_end, input ready);
	modport sink(input valid, input data_byte, input stream_end, output ready);
endinterface

// ----- hdl/hbcd_out_if.sv -----
interface hbcd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       chunk_last;
	logic       body_done;
	logic [1:0] error_code;

	modport source(output valid, output payload_byte, output payload_valid,
		output chunk_last, output body_done, output error_code, input ready);
	modport sink(input valid, input payload_byte, input payload_valid,
		input chunk_last, input body_done, input error_code, output ready);
endinterface

// ----- hdl/hbcd_core.sv -----
`include "http_body_chunked_decoder_unit_defines.svh"

module hbcd_core #(
	parameter int SIZE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hbcd_pkg::cfg_t cfg,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          stream_end,
	output hbcd_pkg::res_t res
);
	import hbcd_pkg::*;

	typedef enum logic [3:0] {
		PH_LINE = 4'b0001,
		PH_CR   = 4'b0010,
		PH_DATA = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [SIZE_BITS-1:0] accum_q, accum_n;
	logic                 digits_q, digits_n;
	logic [SIZE_BITS-1:0] left_q, left_n;
	logic [1:0]           skip_q, skip_n;
	logic                 done_q, done_n;
	logic [1:0]           err_q, err_n;

	logic [SIZE_BITS-1:0] cl_sat;
	logic [SIZE_BITS-1:0] len_left;
	logic                 active;
	hex_t                 hex;

	generate
		if (SIZE_BITS >= CL_BITS) begin : g_cl_wide
			assign cl_sat = SIZE_BITS'(cfg.body_len);
		end else begin : g_cl_sat
			assign cl_sat = (|cfg.body_len[CL_BITS-1:SIZE_BITS]) ? '1 :
				cfg.body_len[SIZE_BITS-1:0];
		end
	endgenerate

	assign active   = (err_q == ERR_NONE) && !done_q;
	assign hex      = hex_decode(data_byte);
	assign len_left = (phase_q != PH_DATA) ? cl_sat : left_q;

	always_comb begin
		phase_n  = phase_q;
		accum_n  = accum_q;
		digits_n = digits_q;
		left_n   = left_q;
		skip_n   = skip_q;
		done_n   = done_q;
		err_n    = err_q;
		res      = '0;
		if (active) begin
			if (cfg.body_mode == MODE_NONE) begin
				done_n = 1'b1;
			end else if (stream_end) begin
				if (cfg.body_mode == MODE_STREAM) begin
					done_n = 1'b1;
				end else begin
					err_n = ERR_EARLY;
				end
			end else if (cfg.body_mode == MODE_LENGTH) begin
				phase_n = PH_DATA;
				left_n  = len_left;
				if (len_left == '0) begin
					done_n = 1'b1;
				end else begin
					res.payload_byte  = data_byte;
					res.payload_valid = 1'b1;
					left_n            = len_left - SIZE_BITS'(1);
					if (len_left == SIZE_BITS'(1)) begin
						done_n = 1'b1;
					end
				end
			end else if (cfg.body_mode == MODE_STREAM) begin
				res.payload_byte  = data_byte;
				res.payload_valid = 1'b1;
			end else begin
				case (phase_q)
					PH_CR: begin
						if (data_byte != CH_LF || !digits_q) begin
							err_n = ERR_LINE;
						end else if (accum_q == '0) begin
							done_n = 1'b1;
						end else begin
							left_n  = accum_q;
							phase_n = PH_DATA;
						end
						accum_n  = '0;
						digits_n = 1'b0;
					end
					PH_DATA: begin
						res.payload_byte  = data_byte;
						res.payload_valid = 1'b1;
						if (left_q[SIZE_BITS-1:1] == '0) begin
							left_n         = '0;
							res.chunk_last = 1'b1;
							phase_n        = PH_SKIP;
							skip_n         = SKIP_COUNT;
						end else begin
							left_n = left_q - SIZE_BITS'(1);
						end
					end
					PH_SKIP: begin
						if (skip_q[1] == 1'b0) begin
							skip_n  = 2'd0;
							phase_n = PH_LINE;
						end else begin
							skip_n = skip_q - 2'd1;
						end
					end
					default: begin
						phase_n = PH_LINE;
						if (data_byte == CH_CR) begin
							phase_n = PH_CR;
						end else if (!hex.ok) begin
							err_n = ERR_LINE;
						end else if (|accum_q[SIZE_BITS-1:SIZE_BITS-4]) begin
							err_n = ERR_OVF;
						end else begin
							accum_n  = {accum_q[SIZE_BITS-5:0], hex.val};
							digits_n = 1'b1;
						end
					end
				endcase
			end
		end
		res.error_code = err_n;
		res.body_done  = (err_n == ERR_NONE) && done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE;
			accum_q  <= '0;
			digits_q <= 1'b0;
			left_q   <= '0;
			skip_q   <= 2'd0;
			done_q   <= 1'b0;
			err_q    <= ERR_NONE;
		end else if (accept) begin
			phase_q  <= phase_n;
			accum_q  <= accum_n;
			digits_q <= digits_n;
			left_q   <= left_n;
			skip_q   <= skip_n;
			done_q   <= done_n;
			err_q    <= err_n;
		end
	end

	`HBCD_ASSERT_NEXT(a_err_sticky, clk, arst_n, err_q != ERR_NONE, $stable(err_q), "error code changed after being set")
	`HBCD_ASSERT_NEXT(a_done_sticky, clk, arst_n, done_q, done_q, "body done flag cleared")
	`HBCD_ASSERT_NOW(a_last_valid, clk, arst_n, res.chunk_last, res.payload_valid, "chunk end without payload")
	`HBCD_ASSERT_NOW(a_pay_active, clk, arst_n, res.payload_valid, active, "payload after done or error")

endmodule

// ----- hdl/hbcd_outbuf.sv -----
`include "http_body_chunked_decoder_unit_defines.svh"

module hbcd_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hbcd_pkg::res_t  push_data,
	output logic            space,
	hbcd_out_if.source      out_ch
);
	import hbcd_pkg::*;

	res_t       mem_q [2];
	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	logic       pop;
	res_t       head;

	assign space = (count_q != 2'd2);
	assign pop   = out_ch.valid && out_ch.ready;
	assign head  = mem_q[rd_q];

	assign out_ch.valid         = (count_q != 2'd0);
	assign out_ch.payload_byte  = head.payload_byte;
	assign out_ch.payload_valid = head.payload_valid;
	assign out_ch.chunk_last    = head.chunk_last;
	assign out_ch.body_done     = head.body_done;
	assign out_ch.error_code    = head.error_code;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`HBCD_ASSERT(a_count_range, clk, arst_n, count_q != 2'd3, "buffer count out of range")
	`HBCD_ASSERT_NOW(a_ptr_even, clk, arst_n, count_q == 2'd0 || count_q == 2'd2, rd_q == wr_q, "pointers disagree with count")
	`HBCD_ASSERT_NOW(a_ptr_odd, clk, arst_n, count_q == 2'd1, rd_q != wr_q, "pointers disagree with single entry")

endmodule

// ----- hdl/http_body_chunked_decoder_unit.sv -----
// Channel  Role    Payload
// in_ch    sink    data_byte[7:0], stream_end
// out_ch   source  payload_byte[7:0], payload_valid, chunk_last, body_done, error_code[1:0]
//
// One result per input byte, one byte per cycle sustained while the output buffer has space.
// Framing state updates in the cycle of the transfer; the result is registered into the output buffer.
// Results sit in a two-entry output buffer; in_ch.ready drops only when both entries are full.
// arst_n clears framing state, flags, config registers and the buffer; no clearing pass.
module http_body_chunked_decoder_unit #(
	parameter int SIZE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	hbcd_in_if.sink     in_ch,
	hbcd_out_if.source  out_ch
);
	import hbcd_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic space;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BODY_MODE: cfg_q.body_mode <= cfg_wdata[1:0];
				CFG_BODY_LEN:  cfg_q.body_len <= cfg_wdata[CL_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = space;
	assign accept      = in_ch.valid && space;

	hbcd_core #(
		.SIZE_BITS(SIZE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.data_byte  (in_ch.data_byte),
		.stream_end (in_ch.stream_end),
		.res        (res)
	);

	hbcd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.space     (space),
		.out_ch    (out_ch)
	);

endmodule
